@@ src/cie_pkg.sv @@
// ----------------------------------------------------------------------------
// cie_pkg
// Shared types, opcodes, selector patterns and status codes of the
// 16-bit instruction execute unit.
// ----------------------------------------------------------------------------
`default_nettype none

package cie_pkg;

	// default stack store depth in bytes (taken as a power of two)
	localparam int unsigned STACK_DEPTH = 256;

	typedef logic [15:0] word_t;
	typedef logic [7:0]  byte_t;

	// general registers in x86 order, segment registers ds/es/ss
	typedef logic [7:0][15:0] gpr_t;
	typedef logic [2:0][15:0] seg_t;

	// status codes
	typedef logic [1:0] status_t;
	localparam status_t ST_OK      = 2'd0;
	localparam status_t ST_HALT    = 2'd1;
	localparam status_t ST_UNKNOWN = 2'd2;

	// general register indexes
	localparam logic [2:0] R_AX = 3'd0;
	localparam logic [2:0] R_CX = 3'd1;
	localparam logic [2:0] R_DX = 3'd2;
	localparam logic [2:0] R_BX = 3'd3;
	localparam logic [2:0] R_SP = 3'd4;
	localparam logic [2:0] R_BP = 3'd5;
	localparam logic [2:0] R_SI = 3'd6;
	localparam logic [2:0] R_DI = 3'd7;

	// segment register indexes
	localparam logic [1:0] S_DS = 2'd0;
	localparam logic [1:0] S_ES = 2'd1;
	localparam logic [1:0] S_SS = 2'd2;

	// full opcodes
	localparam byte_t OP_ALU_IMM16 = 8'h81;
	localparam byte_t OP_ALU_IMM8  = 8'h83;
	localparam byte_t OP_MOV_SEG   = 8'h8E;
	localparam byte_t OP_PUSH_AX   = 8'h50;
	localparam byte_t OP_PUSH_BX   = 8'h53;
	localparam byte_t OP_PUSH_SP   = 8'h54;
	localparam byte_t OP_INT       = 8'hCD;
	localparam byte_t OP_NOP       = 8'h90;
	localparam byte_t OP_HLT       = 8'hF4;

	// opcode groups, matched on the upper bits
	localparam logic [3:0] OPG_INCDEC = 4'h4;
	localparam logic [4:0] OPG_MOVB   = 5'b10110;
	localparam logic [4:0] OPG_MOVW   = 5'b10111;

	// register-select byte patterns, matched on bits 7:3
	localparam logic [4:0] SEL_ADD = 5'b11000;
	localparam logic [4:0] SEL_SUB = 5'b11101;
	localparam logic [4:0] SEL_ES  = 5'b11000;
	localparam logic [4:0] SEL_SS  = 5'b11010;
	localparam logic [4:0] SEL_DS  = 5'b11011;

	// word push toward the stack store
	typedef struct packed {
		logic  en;
		word_t sp;
		word_t data;
	} push_t;

	// everything one instruction produces
	typedef struct packed {
		gpr_t    gpr;
		seg_t    seg;
		logic    halted;
		status_t status;
		push_t   push;
	} exec_t;

endpackage

`default_nettype wire

@@ src/cie_if.sv @@
// ----------------------------------------------------------------------------
// cie_if
// Request and result channel interfaces of the instruction execute unit.
// ----------------------------------------------------------------------------
`default_nettype none

interface cie_in_if;
	logic         valid;
	logic         ready;
	logic [7:0]   command;
	logic [7:0]   reg_select;
	logic [15:0]  immediate;

	modport source (output valid, command, reg_select, immediate, input ready);
	modport sink   (input valid, command, reg_select, immediate, output ready);
endinterface

interface cie_out_if;
	logic         valid;
	logic         ready;
	logic [15:0]  ax_value;
	logic [15:0]  bx_value;
	logic [15:0]  cx_value;
	logic [15:0]  dx_value;
	logic [15:0]  sp_value;
	logic [15:0]  bp_value;
	logic [15:0]  si_value;
	logic [15:0]  di_value;
	logic [15:0]  ds_value;
	logic [15:0]  es_value;
	logic [15:0]  ss_value;
	logic [1:0]   status;

	modport source (output valid, ax_value, bx_value, cx_value, dx_value, sp_value,
		bp_value, si_value, di_value, ds_value, es_value, ss_value, status,
		input ready);
	modport sink   (input valid, ax_value, bx_value, cx_value, dx_value, sp_value,
		bp_value, si_value, di_value, ds_value, es_value, ss_value, status,
		output ready);
endinterface

`default_nettype wire

@@ src/cie_ram.sv @@
// ----------------------------------------------------------------------------
// cie_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cie_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 128
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

@@ src/cie_exec.sv @@
// ----------------------------------------------------------------------------
// cie_exec
// Decode and execute of one instruction against the current register state.
// ----------------------------------------------------------------------------
`default_nettype none

module cie_exec (
	input  wire logic [7:0]      command,
	input  wire logic [7:0]      reg_select,
	input  wire logic [15:0]     immediate,
	input  wire cie_pkg::gpr_t   gpr,
	input  wire cie_pkg::seg_t   seg,
	input  wire logic            halted,
	output cie_pkg::exec_t       res
);

	cie_pkg::word_t operand;
	logic [2:0]     sel_idx;
	logic [2:0]     op_idx;
	logic [2:0]     byte_idx;

	// immediate operand, 8-bit form zero-extended
	assign operand  = (command == cie_pkg::OP_ALU_IMM8) ? {8'h00, immediate[7:0]} : immediate;
	assign sel_idx  = reg_select[2:0];
	assign op_idx   = command[2:0];
	assign byte_idx = {1'b0, command[1:0]};

	// priority decode, one register update per instruction
	always_comb begin
		res.gpr    = gpr;
		res.seg    = seg;
		res.halted = halted;
		res.status = cie_pkg::ST_OK;
		res.push   = '0;

		if (halted) begin
			res.status = cie_pkg::ST_HALT;
		end else if (command == cie_pkg::OP_ALU_IMM16 || command == cie_pkg::OP_ALU_IMM8) begin
			if (reg_select[7:3] == cie_pkg::SEL_ADD) begin
				res.gpr[sel_idx] = gpr[sel_idx] + operand;
			end else if (reg_select[7:3] == cie_pkg::SEL_SUB) begin
				res.gpr[sel_idx] = gpr[sel_idx] - operand;
			end
		end else if (command[7:4] == cie_pkg::OPG_INCDEC) begin
			if (command[3]) begin
				res.gpr[op_idx] = gpr[op_idx] - 16'd1;
			end else begin
				res.gpr[op_idx] = gpr[op_idx] + 16'd1;
			end
		end else if (command[7:3] == cie_pkg::OPG_MOVB) begin
			if (command[2]) begin
				res.gpr[byte_idx] = {immediate[7:0], gpr[byte_idx][7:0]};
			end else begin
				res.gpr[byte_idx] = {gpr[byte_idx][15:8], immediate[7:0]};
			end
		end else if (command[7:3] == cie_pkg::OPG_MOVW) begin
			res.gpr[op_idx] = immediate;
		end else if (command == cie_pkg::OP_MOV_SEG) begin
			if (reg_select[7:3] == cie_pkg::SEL_DS) begin
				res.seg[cie_pkg::S_DS] = gpr[sel_idx];
			end else if (reg_select[7:3] == cie_pkg::SEL_ES) begin
				res.seg[cie_pkg::S_ES] = gpr[sel_idx];
			end else if (reg_select[7:3] == cie_pkg::SEL_SS) begin
				res.seg[cie_pkg::S_SS] = gpr[sel_idx];
			end
		end else if (command == cie_pkg::OP_PUSH_AX || command == cie_pkg::OP_PUSH_BX ||
			command == cie_pkg::OP_PUSH_SP) begin
			// two bytes go out, sp drops by two
			res.push.en = 1'b1;
			res.push.sp = gpr[cie_pkg::R_SP];
			if (command == cie_pkg::OP_PUSH_AX) begin
				res.push.data = gpr[cie_pkg::R_AX];
			end else if (command == cie_pkg::OP_PUSH_BX) begin
				res.push.data = gpr[cie_pkg::R_BX];
			end else begin
				res.push.data = gpr[cie_pkg::R_SP];
			end
			res.gpr[cie_pkg::R_SP] = gpr[cie_pkg::R_SP] - 16'd2;
		end else if (command == cie_pkg::OP_INT || command == cie_pkg::OP_NOP) begin
			res.status = cie_pkg::ST_OK;
		end else if (command == cie_pkg::OP_HLT) begin
			res.halted = 1'b1;
			res.status = cie_pkg::ST_HALT;
		end else begin
			res.status = cie_pkg::ST_UNKNOWN;
		end
	end

endmodule

`default_nettype wire

@@ src/cpu16_instruction_execute_unit.sv @@
// ----------------------------------------------------------------------------
// cpu16_instruction_execute_unit
// Executes one fetched instruction of a 16-bit x86-like subset per request.
//
// The instr channel takes a request (opcode, register-select byte,
// immediate) on valid and ready. It lands in an input register; from there
// one pass of decode and execute updates the register file and loads
// the result register that drives the result channel (all eleven registers
// after the instruction and a status). One request per cycle is sustained
// while the receiver does not stall. Pushes write two bytes into a stack
// store split into an even and an odd bank, so both bytes land in the same
// cycle; the store depth is taken as a power of two.
// Reset clears the general and segment registers, the halt flag and both
// channel valids; the stack store holds no reset value. While the receiver
// stalls the result register holds, one more request waits in the input
// register, and then instr.ready falls. After HLT every request returns
// status halted and changes nothing until reset.
// ----------------------------------------------------------------------------
`default_nettype none

module cpu16_instruction_execute_unit #(
	parameter int unsigned STACK_DEPTH = cie_pkg::STACK_DEPTH
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	cie_in_if.sink     instr,
	cie_out_if.source  result
);

	localparam int unsigned AW    = $clog2(STACK_DEPTH);
	localparam int unsigned BANK  = STACK_DEPTH / 2;

	// input register
	logic        valid_s1;
	logic [7:0]  command_s1;
	logic [7:0]  reg_select_s1;
	logic [15:0] immediate_s1;

	// architectural state
	cie_pkg::gpr_t gpr_q;
	cie_pkg::seg_t seg_q;
	logic          halted_q;

	// result register
	logic             out_valid_q;
	cie_pkg::gpr_t    out_gpr_q;
	cie_pkg::seg_t    out_seg_q;
	cie_pkg::status_t out_status_q;

	cie_pkg::exec_t   ex;
	logic             advance;
	logic             in_take;
	cie_pkg::word_t   sp_m1;
	logic             even_we;
	logic             odd_we;
	logic [AW-2:0]    even_addr;
	logic [AW-2:0]    odd_addr;
	logic [7:0]       even_data;
	logic [7:0]       odd_data;

	// handshake: move s1 into the result register when it is free or drained
	assign advance     = valid_s1 && (!out_valid_q || result.ready);
	assign instr.ready = !valid_s1 || advance;
	assign in_take     = instr.valid && instr.ready;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			command_s1    <= instr.command;
			reg_select_s1 <= instr.reg_select;
			immediate_s1  <= instr.immediate;
		end
	end

	// execute
	cie_exec u_exec (
		.command    (command_s1),
		.reg_select (reg_select_s1),
		.immediate  (immediate_s1),
		.gpr        (gpr_q),
		.seg        (seg_q),
		.halted     (halted_q),
		.res        (ex)
	);

	// register file and halt flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gpr_q    <= '0;
			seg_q    <= '0;
			halted_q <= 1'b0;
		end else if (advance) begin
			gpr_q    <= ex.gpr;
			seg_q    <= ex.seg;
			halted_q <= ex.halted;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_gpr_q    <= ex.gpr;
			out_seg_q    <= ex.seg;
			out_status_q <= ex.status;
		end
	end

	assign result.valid    = out_valid_q;
	assign result.ax_value = out_gpr_q[cie_pkg::R_AX];
	assign result.bx_value = out_gpr_q[cie_pkg::R_BX];
	assign result.cx_value = out_gpr_q[cie_pkg::R_CX];
	assign result.dx_value = out_gpr_q[cie_pkg::R_DX];
	assign result.sp_value = out_gpr_q[cie_pkg::R_SP];
	assign result.bp_value = out_gpr_q[cie_pkg::R_BP];
	assign result.si_value = out_gpr_q[cie_pkg::R_SI];
	assign result.di_value = out_gpr_q[cie_pkg::R_DI];
	assign result.ds_value = out_seg_q[cie_pkg::S_DS];
	assign result.es_value = out_seg_q[cie_pkg::S_ES];
	assign result.ss_value = out_seg_q[cie_pkg::S_SS];
	assign result.status   = out_status_q;

	// stack byte steering: high byte at sp, low byte at sp-1, opposite banks
	assign sp_m1     = ex.push.sp - 16'd1;
	assign even_we   = advance && ex.push.en;
	assign odd_we    = advance && ex.push.en;
	assign even_addr = ex.push.sp[0] ? sp_m1[AW-1:1] : ex.push.sp[AW-1:1];
	assign odd_addr  = ex.push.sp[0] ? ex.push.sp[AW-1:1] : sp_m1[AW-1:1];
	assign even_data = ex.push.sp[0] ? ex.push.data[7:0] : ex.push.data[15:8];
	assign odd_data  = ex.push.sp[0] ? ex.push.data[15:8] : ex.push.data[7:0];

	cie_ram #(
		.WIDTH (8),
		.DEPTH (BANK)
	) u_stack_even (
		.clk   (clk),
		.we    (even_we),
		.waddr (even_addr),
		.wdata (even_data),
		.raddr (even_addr),
		.rdata ()
	);

	cie_ram #(
		.WIDTH (8),
		.DEPTH (BANK)
	) u_stack_odd (
		.clk   (clk),
		.we    (odd_we),
		.waddr (odd_addr),
		.wdata (odd_data),
		.raddr (odd_addr),
		.rdata ()
	);

endmodule

`default_nettype wire

@@ src/cie_checker.sv @@
// ----------------------------------------------------------------------------
// cie_checker
// Port-level checks of the instruction execute unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module cie_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [15:0] ax_value,
	input wire logic [15:0] sp_value,
	input wire logic [1:0]  status
);

	logic        out_take;
	logic        seen_q;
	logic        halt_seen_q;
	logic [15:0] last_ax_q;
	logic [15:0] last_sp_q;

	assign out_take = out_valid && out_ready;

	// track the last delivered result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q      <= 1'b0;
			halt_seen_q <= 1'b0;
			last_ax_q   <= '0;
			last_sp_q   <= '0;
		end else if (out_take) begin
			seen_q      <= 1'b1;
			halt_seen_q <= halt_seen_q || (status == cie_pkg::ST_HALT);
			last_ax_q   <= ax_value;
			last_sp_q   <= sp_value;
		end
	end

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(ax_value) && $stable(status))
		else $error("result changed while stalled");

	// requests are refused only while a result is waiting
	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("request refused without a stalled result");

	// once halted, every later result reports halted with ax and sp unchanged
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		out_take && halt_seen_q |->
			status == cie_pkg::ST_HALT && ax_value == last_ax_q && sp_value == last_sp_q)
		else $error("state changed after halt");

	// an unknown opcode leaves ax and sp unchanged
	a_unknown_noop: assert property (@(posedge clk) disable iff (!arst_n)
		out_take && seen_q && status == cie_pkg::ST_UNKNOWN |->
			ax_value == last_ax_q && sp_value == last_sp_q)
		else $error("unknown opcode changed registers");

	// reset held over an edge leaves both channels empty
	a_reset_empty: assert property (@(posedge clk)
		!arst_n && !$past(arst_n) |-> !out_valid && in_ready)
		else $error("channel not empty during reset");

endmodule

bind cpu16_instruction_execute_unit cie_checker u_cie_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (instr.valid),
	.in_ready  (instr.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.ax_value  (result.ax_value),
	.sp_value  (result.sp_value),
	.status    (result.status)
);

`default_nettype wire
